// File: hw/rtl/pcm_pkg.sv
// Package for the positional PID controller with selectable anti-windup modes.
// Holds field widths, register indexes, mode codes and reset values.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned ILIM_W     = 31;
  localparam int unsigned OLIM_W     = 15;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned ERR_W      = 17;

  // Default clamp on the derivative term in the clamped modes.
  localparam int unsigned DERIV_TERM_LIMIT_DEF = 32767;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE           = 3'd0,
    CFG_PROP_GAIN      = 3'd1,
    CFG_INTEG_GAIN     = 3'd2,
    CFG_DERIV_GAIN     = 3'd3,
    CFG_DEAD_BAND      = 3'd4,
    CFG_INTEGRAL_LIMIT = 3'd5,
    CFG_PROP_LIMIT     = 3'd6,
    CFG_OUTPUT_LIMIT   = 3'd7
  } cfg_idx_e;

  // Controller variants.
  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_SEPARATE = 2'd1;
  localparam logic [1:0] MODE_CLAMP    = 2'd2;
  localparam logic [1:0] MODE_WEAKEN   = 2'd3;

  localparam logic [ILIM_W-1:0] ILIM_RESET = {ILIM_W{1'b1}};
  localparam logic [OLIM_W-1:0] PLIM_RESET = {OLIM_W{1'b1}};
  localparam logic [OLIM_W-1:0] OLIM_RESET = {OLIM_W{1'b1}};

endpackage

// File: hw/rtl/pcm_ifs.sv
// Handshake interfaces of the PID controller: sample input, drive output and
// configuration write channel. Depends on pcm_pkg for payload widths.
`timescale 1ns / 1ps

interface pcm_sample_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pcm_pkg::SAMPLE_W-1:0]       setpoint;
  logic signed [pcm_pkg::SAMPLE_W-1:0]       feedback;

  modport source (output valid, output setpoint, output feedback, input ready);
  modport sink   (input valid, input setpoint, input feedback, output ready);
endinterface

interface pcm_drive_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcm_pkg::DRIVE_W-1:0]  drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

interface pcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcm_pkg::CFG_ADDR_W-1:0]    addr;
  logic [pcm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: hw/rtl/pid_controller_modes.sv
// Top level of the positional PID controller with four anti-windup variants.
// Depends on pcm_pkg and the interfaces in pcm_ifs.sv.
`timescale 1ns / 1ps

// Usage
// sample_i carries one item per handshake: a signed setpoint and a signed
// feedback sample. drive_o returns one signed drive value for every item, in
// the same order. cfg_i writes the eight control registers (mode, three Q8.8
// gains, dead band and three limits) by index; it is always ready, and writes
// are meant to happen only while no item is in flight.
// An item accepted on sample_i sits in the input register, passes through the
// PID arithmetic and lands in the result register once that register is free
// or being emptied, and drive_o then shows it as valid.
// The block takes one item per cycle while drive_o is not stalled, set by the single
// pass through the three gain multipliers and the error sum update, which the next item sees directly.
// If the receiver stalls, the result register holds its item and the input
// register can still take one more item; only then does sample_i drop ready.
// Reset clears the error sum, the previous error and all valid flags, and
// loads the register defaults: mode plain, gains and dead band zero, all
// limits at their maximum.
module pid_controller_modes #(
  parameter int unsigned DERIV_TERM_LIMIT = pcm_pkg::DERIV_TERM_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcm_sample_if.sink  sample_i,
  pcm_drive_if.source drive_o,
  pcm_cfg_if.sink     cfg_i
);

  localparam int unsigned SW = pcm_pkg::SAMPLE_W;
  localparam int unsigned EW = pcm_pkg::ERR_W;
  localparam int unsigned UW = pcm_pkg::SUM_W;
  localparam int unsigned LW = pcm_pkg::ILIM_W;
  localparam int unsigned AW = 42;  // width of the full P + I + D sum
  localparam logic [LW-1:0] DLim = LW'(DERIV_TERM_LIMIT);

  // Symmetric clip; a zero limit gives zero.
  function automatic logic signed [AW-1:0] clip_sym(input logic signed [AW-1:0] x,
                                                    input logic [LW-1:0] lim);
    logic signed [AW-1:0] pos;
    logic signed [AW-1:0] neg;
    pos = $signed({{(AW-LW){1'b0}}, lim});
    neg = -pos;
    if (x <= neg) begin
      return neg;
    end else if (x >= pos) begin
      return pos;
    end
    return x;
  endfunction

  // Configuration registers.
  logic [1:0]                    mode_q;
  logic [pcm_pkg::GAIN_W-1:0]    kp_q, ki_q, kd_q;
  logic [pcm_pkg::BAND_W-1:0]    band_q;
  logic [LW-1:0]                 ilim_q;
  logic [pcm_pkg::OLIM_W-1:0]    plim_q, olim_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pcm_pkg::MODE_PLAIN;
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      band_q <= '0;
      ilim_q <= pcm_pkg::ILIM_RESET;
      plim_q <= pcm_pkg::PLIM_RESET;
      olim_q <= pcm_pkg::OLIM_RESET;
    end else if (cfg_i.valid) begin
      case (pcm_pkg::cfg_idx_e'(cfg_i.addr))
        pcm_pkg::CFG_MODE:           mode_q <= cfg_i.data[1:0];
        pcm_pkg::CFG_PROP_GAIN:      kp_q   <= cfg_i.data[15:0];
        pcm_pkg::CFG_INTEG_GAIN:     ki_q   <= cfg_i.data[15:0];
        pcm_pkg::CFG_DERIV_GAIN:     kd_q   <= cfg_i.data[15:0];
        pcm_pkg::CFG_DEAD_BAND:      band_q <= cfg_i.data[15:0];
        pcm_pkg::CFG_INTEGRAL_LIMIT: ilim_q <= cfg_i.data[LW-1:0];
        pcm_pkg::CFG_PROP_LIMIT:     plim_q <= cfg_i.data[14:0];
        pcm_pkg::CFG_OUTPUT_LIMIT:   olim_q <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied in this cycle.
  logic                 in_valid_q, out_valid_q;
  logic signed [SW-1:0] sp_q, fb_q;
  logic signed [pcm_pkg::DRIVE_W-1:0] drive_q, drive_d;
  logic                 advance, fire;

  assign advance        = !out_valid_q || drive_o.ready;
  assign fire           = in_valid_q && advance;
  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        in_valid_q <= sample_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      sp_q <= sample_i.setpoint;
      fb_q <= sample_i.feedback;
    end
    if (fire) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o.valid = out_valid_q;
  assign drive_o.drive = drive_q;

  // Controller state.
  logic signed [UW-1:0] error_sum_q, error_sum_d;
  logic signed [EW-1:0] last_error_q, last_error_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (fire) begin
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
    end
  end

  // PID arithmetic for the item in the input register.
  logic signed [EW-1:0]   err_raw, err;
  logic [EW-1:0]          abs_raw, abs_err;
  logic                   clamped, band_le, band_lt, acc_en;
  logic signed [UW:0]     sum_wide;
  logic signed [UW-1:0]   sum_sat, sum_upd;
  logic signed [AW-1:0]   sum_clip;
  logic signed [UW-1:0]   sum_use;
  logic signed [EW:0]     diff;
  logic signed [2*UW-1-14:0] i_prod;   // 17 x 32 signed product, 49 bits
  logic signed [2*EW-1:0] p_prod;      // 17 x 17 signed product, 34 bits
  logic signed [2*EW:0]   d_prod;      // 17 x 18 signed product, 35 bits
  logic signed [AW-1:0]   p_term, i_term, d_term, p_use, i_use, d_use, total;

  always_comb begin
    clamped  = mode_q[1];
    err_raw  = EW'(sp_q) - EW'(fb_q);
    abs_raw  = err_raw[EW-1] ? EW'(-err_raw) : EW'(err_raw);
    band_le  = abs_raw <= {1'b0, band_q};
    band_lt  = abs_raw <  {1'b0, band_q};

    // The plain modes zero the error inside the dead band.
    if (!clamped && band_le) begin
      err     = '0;
      abs_err = '0;
    end else begin
      err     = err_raw;
      abs_err = abs_raw;
    end

    // Saturating accumulation of the error.
    acc_en   = !clamped || (mode_q == pcm_pkg::MODE_CLAMP) || band_lt;
    sum_wide = (UW+1)'(error_sum_q) + (UW+1)'(err);
    if (sum_wide[UW] != sum_wide[UW-1]) begin
      sum_sat = sum_wide[UW] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[UW-1:0];
    end
    sum_upd  = acc_en ? sum_sat : error_sum_q;
    sum_clip = clip_sym(AW'(sum_upd), ilim_q);
    sum_use  = clamped ? sum_clip[UW-1:0] : sum_upd;

    // Gain products, floored by an arithmetic shift.
    diff   = (EW+1)'(err) - (EW+1)'(last_error_q);
    p_prod = $signed({1'b0, kp_q}) * err;
    i_prod = $signed({1'b0, ki_q}) * sum_use;
    d_prod = $signed({1'b0, kd_q}) * diff;
    p_term = AW'(p_prod >>> 8);
    i_term = AW'(i_prod >>> 8);
    d_term = AW'(d_prod >>> 8);

    if (clamped) begin
      p_use = clip_sym(p_term, {{(LW-pcm_pkg::OLIM_W){1'b0}}, plim_q});
      d_use = clip_sym(d_term, DLim);
      i_use = i_term;
    end else begin
      p_use = p_term;
      d_use = d_term;
      // Integral separation drops the I term for a large error.
      if ((mode_q == pcm_pkg::MODE_SEPARATE) && ({{(LW-EW){1'b0}}, abs_err} > ilim_q)) begin
        i_use = '0;
      end else begin
        i_use = i_term;
      end
    end

    total   = p_use + i_use + d_use;
    drive_d = pcm_pkg::DRIVE_W'(clip_sym(total, {{(LW-pcm_pkg::OLIM_W){1'b0}}, olim_q}));

    // The clamped mode clears the sum once the error is inside the band.
    if ((mode_q == pcm_pkg::MODE_CLAMP) && band_lt) begin
      error_sum_d = '0;
    end else begin
      error_sum_d = sum_use;
    end
    last_error_d = err;
  end

  // A finished item always shows up in the result register.
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("computed item did not reach the result register");

  // An item held in the input register is not dropped while the output stalls.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled item lost from the input register");

  // The controller state changes only when an item is processed.
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(error_sum_q) && $stable(last_error_q))
    else $error("controller state changed without an item");

  // In the clamped modes the stored sum stays within the integral limit.
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && clamped |=>
      (AW'(error_sum_q) <= $signed({{(AW-LW){1'b0}}, $past(ilim_q)})) &&
      (AW'(error_sum_q) >= -$signed({{(AW-LW){1'b0}}, $past(ilim_q)})))
    else $error("error sum outside the integral limit");

endmodule
